>>> design/lru_pkg.sv
// Shared constants, types and helpers for the LRU page replacement block.
`default_nettype none

package lru_pkg;

  // Table geometry
  localparam int unsigned FRAMES  = 64;
  localparam int unsigned IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W   = $clog2(FRAMES + 1);

  // Field widths of the channels
  localparam int unsigned TAG_W   = 31;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned FAULT_W = 32;
  localparam int unsigned CFG_W   = 7;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(64);
  localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

  // Search token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic             live;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic             empty_found;
    logic [IDX_W-1:0] empty_idx;
    logic             min_found;
    logic [IDX_W-1:0] min_idx;
    logic [IDX_W-1:0] min_rank;
  } tok_t;

  // Lookup key broadcast to every cell while a reference is in flight
  typedef struct packed {
    logic [TAG_W-1:0] page;
    logic [CNT_W-1:0] active;
  } look_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic             clear;
    logic             apply;
    logic             fill;
    logic             promote;
    logic             write_tag;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] old_rank;
    logic [IDX_W-1:0] new_rank;
  } upd_t;

  // Bound the frame count register to 1 .. FRAMES
  function automatic logic [CNT_W-1:0] clamp_active(input logic [CFG_W-1:0] cfg);
    logic [31:0] v;
    v = 32'(cfg);
    if (v == 32'd0) begin
      v = 32'd1;
    end
    if (v > 32'(FRAMES)) begin
      v = 32'(FRAMES);
    end
    return CNT_W'(v);
  endfunction

endpackage

`default_nettype wire

>>> design/lru_if.sv
// Channel interfaces: page references in, results out, frame count writes.
`default_nettype none

interface lru_page_if;
  logic                       valid;
  logic                       ready;
  logic [lru_pkg::TAG_W-1:0]  page_number;
  logic                       restart;

  modport source (output valid, output page_number, output restart, input ready);
  modport sink   (input valid, input page_number, input restart, output ready);
endinterface

interface lru_result_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lru_pkg::SLOT_W-1:0]   frame_slot;
  logic [lru_pkg::FAULT_W-1:0]  fault_count;

  modport source (output valid, output hit, output frame_slot, output fault_count,
                  input ready);
  modport sink   (input valid, input hit, input frame_slot, input fault_count,
                  output ready);
endinterface

interface lru_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lru_pkg::CFG_W-1:0]  frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

>>> design/lru_cell.sv
// One frame of the table: tag, valid, recency rank, and one stage of the search chain.
`default_nettype none

module lru_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lru_pkg::IDX_W-1:0]   cell_idx_i,
  input  wire lru_pkg::look_t              look_i,
  input  wire lru_pkg::upd_t               upd_i,
  input  wire lru_pkg::tok_t               tok_i,
  output lru_pkg::tok_t                    tok_o
);

  logic [lru_pkg::TAG_W-1:0] tag_q;
  logic                      valid_q;
  logic [lru_pkg::IDX_W-1:0] rank_q;
  lru_pkg::tok_t             tok_d;
  lru_pkg::tok_t             tok_q;
  logic                      in_range;
  logic                      match;
  logic                      is_slot;

  assign in_range = lru_pkg::CNT_W'(cell_idx_i) < look_i.active;
  assign match    = in_range && valid_q && (tag_q == look_i.page);
  assign is_slot  = (cell_idx_i == upd_i.slot);

  // Fold this frame into the passing token
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit_found && match) begin
      tok_d.hit_found = 1'b1;
      tok_d.hit_idx   = cell_idx_i;
      tok_d.hit_rank  = rank_q;
    end
    if (!tok_i.empty_found && in_range && !valid_q) begin
      tok_d.empty_found = 1'b1;
      tok_d.empty_idx   = cell_idx_i;
    end
    if (in_range && (!tok_i.min_found || (rank_q < tok_i.min_rank))) begin
      tok_d.min_found = 1'b1;
      tok_d.min_idx   = cell_idx_i;
      tok_d.min_rank  = rank_q;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // Empty, fill or reorder the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.clear) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.apply) begin
      if (is_slot) begin
        rank_q <= upd_i.new_rank;
        if (upd_i.fill) begin
          valid_q <= 1'b1;
        end
      end else if (upd_i.promote && valid_q && (rank_q > upd_i.old_rank)) begin
        rank_q <= rank_q - lru_pkg::IDX_W'(1);
      end
    end
  end

  // Load the new page on a fault
  always_ff @(posedge clk_i) begin
    if (upd_i.apply && upd_i.write_tag && is_slot) begin
      tag_q <= look_i.page;
    end
  end

endmodule

`default_nettype wire

>>> design/lru_page_replacement.sv
// Top level: reference sequencer, fault counter, result register and the chain of frame cells.
// References are handled one at a time: a new one is taken only once the last one has committed;
//   the search token steps through the 64-cell chain one cell per clock.
// Reset: all frames empty, ranks and fault count zero, frames_in_use back to 64;
//   frame tags are not cleared and no clearing pass runs, so input is taken right away.
`default_nettype none

module lru_page_replacement (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lru_page_if.sink      ref_i,
  lru_result_if.source  res_o,
  lru_cfg_if.sink       cfg_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [lru_pkg::CFG_W-1:0]     frames_q;
  lru_pkg::look_t                look_q;
  logic [lru_pkg::CNT_W-1:0]     vcount_q;
  logic [lru_pkg::CNT_W-1:0]     vcount_dec;
  logic [lru_pkg::FAULT_W-1:0]   faults_q;
  logic [lru_pkg::FAULT_W-1:0]   faults_inc;
  lru_pkg::tok_t                 fin_q;
  lru_pkg::tok_t                 tok_w [0:lru_pkg::FRAMES];
  lru_pkg::upd_t                 upd;
  logic                          in_xfer;
  logic                          commit;
  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [lru_pkg::SLOT_W-1:0]    out_slot_q;
  logic [lru_pkg::FAULT_W-1:0]   out_fault_q;

  assign ref_i.ready = (state_q == ST_IDLE);
  assign in_xfer     = ref_i.valid && ref_i.ready;
  assign commit      = (state_q == ST_COMMIT) && (!out_valid_q || res_o.ready);
  assign vcount_dec  = vcount_q - lru_pkg::CNT_W'(1);
  assign faults_inc  = (faults_q == lru_pkg::FAULT_MAX) ? faults_q
                                                         : faults_q + lru_pkg::FAULT_W'(1);

  // Frame count register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lru_pkg::FRAMES_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      frames_q <= cfg_i.frames_in_use;
    end
  end

  // Sequence one reference: launch the token, wait for it at the chain end, commit
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok_w[lru_pkg::FRAMES].live) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the lookup key on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      look_q.page   <= ref_i.page_number;
      look_q.active <= lru_pkg::clamp_active(frames_q);
    end
  end

  // Capture the finished token
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && tok_w[lru_pkg::FRAMES].live) begin
      fin_q <= tok_w[lru_pkg::FRAMES];
    end
  end

  // Start token enters cell 0 for one cycle
  always_comb begin
    tok_w[0]      = '0;
    tok_w[0].live = (state_q == ST_LAUNCH);
  end

  // Build the table update: empty on restart, then hit, fill or evict
  always_comb begin
    upd       = '0;
    upd.clear = in_xfer && ref_i.restart;
    if (commit) begin
      upd.apply = 1'b1;
      if (fin_q.hit_found) begin
        upd.promote  = 1'b1;
        upd.slot     = fin_q.hit_idx;
        upd.old_rank = fin_q.hit_rank;
        upd.new_rank = lru_pkg::IDX_W'(vcount_dec);
      end else if (fin_q.empty_found) begin
        upd.fill      = 1'b1;
        upd.write_tag = 1'b1;
        upd.slot      = fin_q.empty_idx;
        upd.new_rank  = lru_pkg::IDX_W'(vcount_q);
      end else begin
        upd.promote   = 1'b1;
        upd.write_tag = 1'b1;
        upd.slot      = fin_q.min_idx;
        upd.old_rank  = fin_q.min_rank;
        upd.new_rank  = lru_pkg::IDX_W'(vcount_dec);
      end
    end
  end

  // Track valid frames and faults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      faults_q <= '0;
    end else if (upd.clear) begin
      vcount_q <= '0;
      faults_q <= '0;
    end else if (commit) begin
      if (upd.fill) begin
        vcount_q <= vcount_q + lru_pkg::CNT_W'(1);
      end
      if (!fin_q.hit_found) begin
        faults_q <= faults_inc;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_hit_q   <= fin_q.hit_found;
      out_slot_q  <= lru_pkg::SLOT_W'(upd.slot);
      out_fault_q <= fin_q.hit_found ? faults_q : faults_inc;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.hit         = out_hit_q;
  assign res_o.frame_slot  = out_slot_q;
  assign res_o.fault_count = out_fault_q;

  // Chain of frame cells
  for (genvar i = 0; i < lru_pkg::FRAMES; i++) begin : g_cell
    lru_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (lru_pkg::IDX_W'(i)),
      .look_i     (look_q),
      .upd_i      (upd),
      .tok_i      (tok_w[i]),
      .tok_o      (tok_w[i+1])
    );
  end

endmodule

`default_nettype wire

>>> design/lru_checker.sv
// Port-level checks for the LRU page replacement block and their bind.
`default_nettype none

module lru_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic                          hit_i,
  input wire logic [lru_pkg::SLOT_W-1:0]    frame_slot_i,
  input wire logic [lru_pkg::FAULT_W-1:0]   fault_count_i
);

  // One reference at a time: busy right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still ready after a transfer");

  // A fault always leaves a nonzero count
  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !hit_i) |-> (fault_count_i != '0))
    else $error("fault reported with zero fault count");

  // A new result only appears while a reference is in flight
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared with no reference in flight");

  // Hold a stalled result
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(hit_i) && $stable(frame_slot_i) && $stable(fault_count_i)))
    else $error("stalled result changed");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (ref_i.valid),
  .in_ready_i    (ref_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .hit_i         (res_o.hit),
  .frame_slot_i  (res_o.frame_slot),
  .fault_count_i (res_o.fault_count)
);

`default_nettype wire
